>>> rtl/pfma_pkg.sv
// Package for the prime-field modular ALU.
// Operation codes, count widths and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package pfma_pkg;

    localparam int DEF_RESIDUE_WIDTH = 32;
    localparam int VALUE_WIDTH       = 64;
    localparam int CNT_WIDTH         = 7;   // holds a count of up to VALUE_WIDTH steps

    typedef enum logic [2:0] {
        FUNC_REDUCE = 3'd0,
        FUNC_ADD    = 3'd1,
        FUNC_SUB    = 3'd2,
        FUNC_MUL    = 3'd3,
        FUNC_DIV    = 3'd4,
        FUNC_NEG    = 3'd5,
        FUNC_CMP    = 3'd6,
        FUNC_NONE   = 3'd7
    } func_t;

endpackage

>>> rtl/prime_field_modular_alu_top.sv
// Prime-field modular ALU: one shared shift-subtract unit and modular add/subtract logic
// stepped by a sequencer. Depends on pfma_pkg. Divide runs Euclid steps on (b, p).
// One item at a time: s_tready only when idle, and a stalled result holds the sequencer
// until it is taken.
// Reset (rst_n low, asynchronous): sequencer idle, no result pending, modulus = 1.
`timescale 1ns / 1ps

module prime_field_modular_alu_top #(
    parameter int RESIDUE_WIDTH = pfma_pkg::DEF_RESIDUE_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration: modulus p
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b, [127:64] signed_value
    input  logic [2:0]   s_tuser,   // [2:0] func
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [31:0] result
    output logic [1:0]   m_tuser    // [0] less_flag, [1] no_inverse
);

    localparam int W     = RESIDUE_WIDTH;
    localparam int VW    = pfma_pkg::VALUE_WIDTH;
    localparam int CW    = pfma_pkg::CNT_WIDTH;
    localparam int ALIGN = VW - W;   // left-aligns a residue in the dividend shifter

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,       // restoring division step, remainder only
        S_EXEC,      // single-step operations and dispatch
        S_EU_CHK,    // Euclid loop test
        S_EU_DIV,    // quotient bit + double of q*s accumulator
        S_EU_ADD,    // conditional add of s into accumulator
        S_EU_UPD,    // rotate remainder / coefficient pairs
        S_MUL_DBL,
        S_MUL_ADD,
        S_FIN        // load output register
    } state_t;

    typedef enum logic [1:0] {
        RED_SV,
        RED_A,
        RED_B
    } red_sel_t;

    // modular helpers, operands below p
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] p);
        logic [W-1:0] gap;
        gap = p - y;
        return (x >= gap) ? (x - gap) : (x + y);
    endfunction

    function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] p);
        return (x >= y) ? (x - y) : (x + (p - y));
    endfunction

    state_t          state_reg;
    red_sel_t        red_sel_reg;
    pfma_pkg::func_t func_reg;
    logic [W-1:0]    mod_reg;
    logic [W-1:0]    p_reg;
    logic [W-1:0]    a_reg, b_reg;
    logic [W-1:0]    raw_b_reg;
    logic            sv_neg_reg;
    logic [VW-1:0]   dvd_reg;
    logic [W-1:0]    rem_reg;
    logic [CW-1:0]   cnt_reg;
    logic            qbit_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    mpl_reg;
    logic [W-1:0]    old_r_reg, r_reg, old_s_reg, s_reg;
    logic [W-1:0]    res_reg;
    logic            less_reg, noinv_reg;
    logic            m_tvalid_reg;
    logic [31:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    // input field unpacking, masked to the residue width
    logic [VW-1:0] a_ext, b_ext, cfg_ext, sv_mag, res_ext;
    logic [W-1:0]  ra, rb, cfg_p;
    logic [VW-1:0] sv;

    assign a_ext   = VW'(s_tdata[31:0]);
    assign b_ext   = VW'(s_tdata[63:32]);
    assign cfg_ext = VW'(cfg_wr_data);
    assign ra      = a_ext[W-1:0];
    assign rb      = b_ext[W-1:0];
    assign cfg_p   = cfg_ext[W-1:0];
    assign sv      = s_tdata[127:64];
    assign sv_mag  = sv[VW-1] ? (VW'(0) - sv) : sv;
    assign res_ext = VW'(res_reg);

    // shared shift-subtract step
    logic [W-1:0] divisor;
    logic [W:0]   rem_sh;
    logic         rem_ge;
    logic [W:0]   rem_sub;

    assign divisor = (state_reg == S_RED) ? p_reg : r_reg;
    assign rem_sh  = {rem_reg, dvd_reg[VW-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mod_reg      <= W'(1);
            m_tvalid_reg <= 1'b0;
            red_sel_reg  <= RED_A;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mod_reg <= cfg_p;
            end
            // S_FIN handles the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg   <= pfma_pkg::func_t'(s_tuser);
                        p_reg      <= mod_reg;
                        raw_b_reg  <= rb;
                        sv_neg_reg <= sv[VW-1];
                        res_reg    <= '0;
                        rem_reg    <= '0;
                        if (mod_reg == '0)
                        begin
                            // zero modulus: no arithmetic, flags only
                            noinv_reg <= (pfma_pkg::func_t'(s_tuser) == pfma_pkg::FUNC_DIV);
                            less_reg  <= (pfma_pkg::func_t'(s_tuser) == pfma_pkg::FUNC_CMP)
                                         && (ra < rb);
                            state_reg <= S_FIN;
                        end
                        else if (pfma_pkg::func_t'(s_tuser) == pfma_pkg::FUNC_REDUCE)
                        begin
                            less_reg    <= 1'b0;
                            noinv_reg   <= 1'b0;
                            dvd_reg     <= sv_mag;
                            cnt_reg     <= CW'(VW);
                            red_sel_reg <= RED_SV;
                            state_reg   <= S_RED;
                        end
                        else
                        begin
                            less_reg    <= 1'b0;
                            noinv_reg   <= 1'b0;
                            dvd_reg     <= VW'(ra) << ALIGN;
                            cnt_reg     <= CW'(W);
                            red_sel_reg <= RED_A;
                            state_reg   <= S_RED;
                        end
                    end
                end

                S_RED:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        case (red_sel_reg)
                            RED_SV:
                            begin
                                state_reg <= S_FIN;
                                if (!sv_neg_reg)
                                begin
                                    res_reg <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                                end
                                else if (rem_ge ? (rem_sub[W-1:0] == '0)
                                                : (rem_sh[W-1:0] == '0))
                                begin
                                    res_reg <= '0;
                                end
                                else
                                begin
                                    res_reg <= p_reg - (rem_ge ? rem_sub[W-1:0]
                                                               : rem_sh[W-1:0]);
                                end
                            end
                            RED_A:
                            begin
                                a_reg       <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                                dvd_reg     <= VW'(raw_b_reg) << ALIGN;
                                rem_reg     <= '0;
                                cnt_reg     <= CW'(W);
                                red_sel_reg <= RED_B;
                            end
                            default:
                            begin
                                b_reg     <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                                state_reg <= S_EXEC;
                            end
                        endcase
                    end
                    else
                    begin
                        dvd_reg <= dvd_reg << 1;
                        rem_reg <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end

                S_EXEC:
                begin
                    case (func_reg)
                        pfma_pkg::FUNC_ADD:
                        begin
                            res_reg   <= add_mod(a_reg, b_reg, p_reg);
                            state_reg <= S_FIN;
                        end
                        pfma_pkg::FUNC_SUB:
                        begin
                            res_reg   <= sub_mod(a_reg, b_reg, p_reg);
                            state_reg <= S_FIN;
                        end
                        pfma_pkg::FUNC_NEG:
                        begin
                            res_reg   <= sub_mod('0, a_reg, p_reg);
                            state_reg <= S_FIN;
                        end
                        pfma_pkg::FUNC_CMP:
                        begin
                            less_reg  <= (a_reg < b_reg);
                            state_reg <= S_FIN;
                        end
                        pfma_pkg::FUNC_MUL:
                        begin
                            acc_reg   <= '0;
                            mpl_reg   <= b_reg;
                            cnt_reg   <= CW'(W);
                            state_reg <= S_MUL_DBL;
                        end
                        pfma_pkg::FUNC_DIV:
                        begin
                            old_r_reg <= b_reg;
                            r_reg     <= p_reg;
                            old_s_reg <= (p_reg == W'(1)) ? '0 : W'(1);
                            s_reg     <= '0;
                            state_reg <= S_EU_CHK;
                        end
                        default:
                        begin
                            res_reg   <= '0;
                            state_reg <= S_FIN;
                        end
                    endcase
                end

                S_EU_CHK:
                begin
                    if (r_reg == '0)
                    begin
                        if (old_r_reg == W'(1))
                        begin
                            // inverse found: a * old_s
                            acc_reg   <= '0;
                            mpl_reg   <= old_s_reg;
                            cnt_reg   <= CW'(W);
                            state_reg <= S_MUL_DBL;
                        end
                        else
                        begin
                            noinv_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        dvd_reg   <= VW'(old_r_reg) << ALIGN;
                        rem_reg   <= '0;
                        acc_reg   <= '0;
                        cnt_reg   <= CW'(W);
                        state_reg <= S_EU_DIV;
                    end
                end

                // quotient bits come MSB first, so q*s mod p is built alongside
                S_EU_DIV:
                begin
                    dvd_reg   <= dvd_reg << 1;
                    rem_reg   <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                    qbit_reg  <= rem_ge;
                    acc_reg   <= add_mod(acc_reg, acc_reg, p_reg);
                    state_reg <= S_EU_ADD;
                end

                S_EU_ADD:
                begin
                    if (qbit_reg)
                    begin
                        acc_reg <= add_mod(acc_reg, s_reg, p_reg);
                    end
                    cnt_reg   <= cnt_reg - CW'(1);
                    state_reg <= (cnt_reg == CW'(1)) ? S_EU_UPD : S_EU_DIV;
                end

                S_EU_UPD:
                begin
                    old_r_reg <= r_reg;
                    r_reg     <= rem_reg;
                    old_s_reg <= s_reg;
                    s_reg     <= sub_mod(old_s_reg, acc_reg, p_reg);
                    state_reg <= S_EU_CHK;
                end

                S_MUL_DBL:
                begin
                    acc_reg   <= add_mod(acc_reg, acc_reg, p_reg);
                    state_reg <= S_MUL_ADD;
                end

                S_MUL_ADD:
                begin
                    if (mpl_reg[W-1])
                    begin
                        acc_reg <= add_mod(acc_reg, a_reg, p_reg);
                        res_reg <= add_mod(acc_reg, a_reg, p_reg);
                    end
                    else
                    begin
                        res_reg <= acc_reg;
                    end
                    mpl_reg   <= mpl_reg << 1;
                    cnt_reg   <= cnt_reg - CW'(1);
                    state_reg <= (cnt_reg == CW'(1)) ? S_FIN : S_MUL_DBL;
                end

                S_FIN:
                begin
                    // hold here while a previous result is still unclaimed
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_ext[31:0];
                        m_tuser_reg  <= {noinv_reg, less_reg};
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/pfma_checker.sv
// Port-level checks for the prime-field modular ALU, bound to its top level.
// Depends on prime_field_modular_alu_top.
`timescale 1ns / 1ps

module pfma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second item while busy");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("less and no-inverse flags both set");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("compare item with nonzero residue");

    a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
        else $error("no-inverse item with nonzero residue");

endmodule

bind prime_field_modular_alu_top pfma_checker u_pfma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb.sv
// Self-checking testbench for prime_field_modular_alu_top: directed corner items,
// then moduli 0 to 2, then random phases over several moduli, each result checked in order.
// Depends on pfma_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [31:0] residue;
        logic        less_flag;
        logic        no_inverse;
    } alu_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;     // [31:0] operand_a, [63:32] operand_b, [127:64] signed_value
    logic [2:0]   s_tuser;     // [2:0] func
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;     // [31:0] result
    logic [1:0]   m_tuser;     // [0] less_flag, [1] no_inverse

    alu_result_t  pending_q[$];
    logic [31:0]  modulus_now;
    bit           idling_on;
    int           stall_left;
    int           error_count;
    int           item_count;
    int           result_count;
    int           phase_count;

    prime_field_modular_alu_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // modular inverse by extended Euclid; returns 0 when gcd(b, p) != 1
    function automatic bit mod_inverse(logic [63:0] b, logic [63:0] p, output logic [63:0] inv);
        longint r_prev;
        longint r_cur;
        longint s_prev;
        longint s_cur;
        longint quot;
        longint tmp;
        r_prev = longint'(b);
        r_cur  = longint'(p);
        s_prev = 1;
        s_cur  = 0;
        while (r_cur != 0)
        begin
            quot   = r_prev / r_cur;
            tmp    = r_prev - quot * r_cur;
            r_prev = r_cur;
            r_cur  = tmp;
            tmp    = s_prev - quot * s_cur;
            s_prev = s_cur;
            s_cur  = tmp;
        end
        s_prev = s_prev % longint'(p);
        if (s_prev < 0)
            s_prev += longint'(p);
        inv = 64'(s_prev);
        return (r_prev == 1);
    endfunction

    // expected result of one item under the current modulus
    function automatic alu_result_t alu_predict(pfma_pkg::func_t op, logic [31:0] a_raw,
                                                logic [31:0] b_raw, logic [63:0] sval,
                                                logic [31:0] pmod);
        alu_result_t r;
        logic [63:0] p;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag;
        logic [63:0] inv;
        r = '0;
        p = 64'(pmod);
        if (p == 0)
        begin
            if (op == pfma_pkg::FUNC_DIV)
                r.no_inverse = 1'b1;
            else if (op == pfma_pkg::FUNC_CMP)
                r.less_flag = (a_raw < b_raw);
            return r;
        end
        a = 64'(a_raw) % p;
        b = 64'(b_raw) % p;
        case (op)
            pfma_pkg::FUNC_REDUCE:
            begin
                if (!sval[63])
                    r.residue = 32'(sval % p);
                else
                begin
                    mag = (64'd0 - sval) % p;
                    r.residue = (mag == 0) ? 32'd0 : 32'(p - mag);
                end
            end
            pfma_pkg::FUNC_ADD: r.residue = 32'((a + b) % p);
            pfma_pkg::FUNC_SUB: r.residue = 32'((a + p - b) % p);
            pfma_pkg::FUNC_MUL: r.residue = 32'((a * b) % p);
            pfma_pkg::FUNC_DIV:
            begin
                if (mod_inverse(b, p, inv))
                    r.residue = 32'((a * inv) % p);
                else
                    r.no_inverse = 1'b1;
            end
            pfma_pkg::FUNC_NEG: r.residue = 32'((p - a) % p);
            pfma_pkg::FUNC_CMP: r.less_flag = (a < b);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%08h expected 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    // result checker: outputs sampled at the rising edge
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected item", m_tdata, 32'd0);
            else
            begin
                want = pending_q.pop_front();
                result_count++;
                if (m_tdata !== want.residue)
                    report_mismatch("result", m_tdata, want.residue);
                if (m_tuser[0] !== want.less_flag)
                    report_mismatch("less_flag", 32'(m_tuser[0]), 32'(want.less_flag));
                if (m_tuser[1] !== want.no_inverse)
                    report_mismatch("no_inverse", 32'(m_tuser[1]), 32'(want.no_inverse));
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // send one item; starts just after an edge, returns right after acceptance
    task automatic send_item(pfma_pkg::func_t op, logic [31:0] a, logic [31:0] b,
                             logic [63:0] sval);
        int gap;
        gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= {sval, b, a};
        s_tvalid <= 1'b1;
        #1;
        // s_tready only changes on a rising edge, so its value here holds for the next edge
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        pending_q.push_back(alu_predict(op, a, b, sval, modulus_now));
        item_count++;
    endtask

    // drain the block, then write the modulus while nothing is in flight
    task automatic set_modulus(logic [31:0] p);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        modulus_now = p;
        phase_count++;
    endtask

    // operand mostly a residue below p, sometimes an edge or a raw word
    function automatic logic [31:0] pick_operand(logic [31:0] p);
        int sel;
        sel = $urandom_range(0, 19);
        if (p == 0 || sel == 0)
            return $urandom;
        if (sel == 1)
            return 32'd0;
        if (sel == 2)
            return p - 32'd1;
        return $urandom % p;
    endfunction

    function automatic logic [63:0] pick_value(logic [31:0] p);
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return -(64'(p) * 64'($urandom_range(1, 1000)));    // exact negative multiple
            1: return 64'(p) * 64'($urandom_range(0, 1000));
            2: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] p;
        p = 32'd4294967291;     // largest 32-bit prime
        set_modulus(p);
        send_item(pfma_pkg::FUNC_REDUCE, 0, 0, 64'h8000_0000_0000_0000);
        send_item(pfma_pkg::FUNC_REDUCE, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(pfma_pkg::FUNC_REDUCE, 0, 0, -64'(p));
        send_item(pfma_pkg::FUNC_REDUCE, 0, 0, -(64'(p) * 64'd3));
        send_item(pfma_pkg::FUNC_REDUCE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pfma_pkg::FUNC_ADD, p - 1, p - 1, 0);
        send_item(pfma_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);  // operands not below p
        send_item(pfma_pkg::FUNC_SUB, 0, p - 1, 0);
        send_item(pfma_pkg::FUNC_SUB, p - 1, 0, 0);
        send_item(pfma_pkg::FUNC_MUL, p - 1, p - 1, 0);
        send_item(pfma_pkg::FUNC_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
        send_item(pfma_pkg::FUNC_DIV, 5, 0, 0);                          // zero divisor
        send_item(pfma_pkg::FUNC_DIV, p - 1, 1, 0);
        send_item(pfma_pkg::FUNC_DIV, 1, p - 1, 0);
        send_item(pfma_pkg::FUNC_DIV, 7, p, 0);                          // divisor reduces to zero
        send_item(pfma_pkg::FUNC_NEG, 0, 0, 0);
        send_item(pfma_pkg::FUNC_NEG, p - 1, 0, 0);
        send_item(pfma_pkg::FUNC_CMP, 3, 4, 0);
        send_item(pfma_pkg::FUNC_CMP, 4, 4, 0);
        send_item(pfma_pkg::FUNC_CMP, 32'hFFFF_FFFF, 5, 0);              // compares reduced values
        send_item(pfma_pkg::FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        set_modulus(32'd10);
        send_item(pfma_pkg::FUNC_DIV, 3, 4, 0);                          // shared factor with p
        send_item(pfma_pkg::FUNC_DIV, 3, 7, 0);
    endtask

    task automatic test_small_moduli();
        logic [31:0] p;
        for (int m = 0; m < 3; m++)
        begin
            set_modulus(32'(m));
            for (int f = 0; f < 8; f++)
            begin
                p = 32'(m);
                send_item(pfma_pkg::func_t'(f), $urandom, $urandom, pick_value(p));
            end
        end
    endtask

    task automatic test_random(int per_phase);
        logic [31:0] p;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: p = 32'd4294967291;
                1: p = 32'd97;
                2: p = 32'd65536;
                3: p = $urandom | 32'h8000_0001;
                4: p = $urandom_range(2, 1000);
                5: p = 32'hFFFF_FFFF;
                6: p = $urandom_range(0, 1);
                default: p = 32'd2147483647;
            endcase
            idling_on = (ph != 7);      // last phase runs without gaps or stalls
            set_modulus(p);
            repeat (per_phase)
                send_item(pfma_pkg::func_t'($urandom_range(0, 7)), pick_operand(p),
                          pick_operand(p), pick_value(p));
        end
    endtask

    initial
    begin
        int waited;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        modulus_now = 32'd1;
        idling_on   = 1'b1;
        stall_left  = 0;
        error_count = 0;
        item_count  = 0;
        result_count = 0;
        phase_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(pfma_pkg::FUNC_ADD, 0, 0, 0);   // reset modulus of one
        test_directed();
        test_small_moduli();
        test_random(140);

        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_q.size() != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (300) @(negedge clk);

        $display("Ran %0d items over %0d modulus settings, %0d results checked.",
                 item_count, phase_count, result_count);
        $display("Covered all funcs incl. divide without inverse, moduli 0, 1 and 32-bit primes.");
        if (error_count == 0 && pending_q.size() == 0)
            $display("Verification passed");
        else
        begin
            if (pending_q.size() != 0)
                $display("%0d expected results never arrived", pending_q.size());
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run (every item a worst-case divide)
    initial
    begin
        #150_000_000;
        $display("Timeout at %0t", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
